// File: rtl/core/cma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// shared types and fixed field widths of the contour moment accumulator
// ----------------------------------------------------------------------------
package cma_pkg;

  // fixed widths of the channel fields
  localparam int unsigned CoordW = 12;
  localparam int unsigned AreaW  = 26;
  localparam int unsigned Mom1W  = 40;
  localparam int unsigned Mom2W  = 54;
  localparam int unsigned NumMom = 6;

  // slot of each running total
  typedef enum logic [2:0] {
    MOM_00,
    MOM_10,
    MOM_01,
    MOM_11,
    MOM_20,
    MOM_02
  } mom_idx_t;

  // one edge for the arithmetic back end
  typedef struct packed {
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x2;
    logic [CoordW-1:0] y2;
    logic              clear;  // zero the totals before adding this edge
    logic              emit;   // present the totals after adding this edge
  } cma_seg_t;

endpackage

// File: rtl/core/cma_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_channels
// valid/ready channel interfaces for vertices and moment results
// ----------------------------------------------------------------------------
interface cma_vertex_if import cma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] vertex_x;
  logic [CoordW-1:0] vertex_y;
  logic              last_vertex;
  logic              new_region;

  modport source (output valid, vertex_x, vertex_y, last_vertex, new_region, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, new_region, output ready);
endinterface

interface cma_moment_if import cma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AreaW-1:0] area_x2;
  logic signed [Mom1W-1:0] moment_x_x6;
  logic signed [Mom1W-1:0] moment_y_x6;
  logic signed [Mom2W-1:0] moment_xy_x24;
  logic signed [Mom2W-1:0] moment_xx_x12;
  logic signed [Mom2W-1:0] moment_yy_x12;

  modport source (output valid, area_x2, moment_x_x6, moment_y_x6, moment_xy_x24,
                  moment_xx_x12, moment_yy_x12, input ready);
  modport sink   (input valid, area_x2, moment_x_x6, moment_y_x6, moment_xy_x24,
                  moment_xx_x12, moment_yy_x12, output ready);
endinterface

// File: rtl/core/cma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_front
// vertex intake: tracks first and previous vertex, turns vertices into edges
// ----------------------------------------------------------------------------
module cma_front import cma_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  cma_vertex_if.sink in_ch,
  output cma_seg_t   seg_data,
  output logic       seg_valid,
  input  logic       seg_ready
);

  localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << COORD_BITS) - 1);

  logic [CoordW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic              in_contour_r, in_contour_nxt;
  logic              close_pend_r, close_pend_nxt;
  logic [CoordW-1:0] vx, vy;
  logic              take;

  assign vx          = in_ch.vertex_x & CoordMask;
  assign vy          = in_ch.vertex_y & CoordMask;
  assign in_ch.ready = seg_ready && !close_pend_r;
  assign take        = in_ch.valid && in_ch.ready;
  assign seg_valid   = close_pend_r || in_ch.valid;

  always_comb begin
    if (close_pend_r) begin
      // closing edge back to the first vertex
      seg_data = '{x1: prev_x_r, y1: prev_y_r, x2: first_x_r, y2: first_y_r,
                   clear: 1'b0, emit: 1'b1};
    end else if (!in_contour_r) begin
      // first vertex: degenerate edge carries the clear and a lone-vertex emit
      seg_data = '{x1: vx, y1: vy, x2: vx, y2: vy,
                   clear: in_ch.new_region, emit: in_ch.last_vertex};
    end else begin
      seg_data = '{x1: prev_x_r, y1: prev_y_r, x2: vx, y2: vy,
                   clear: 1'b0, emit: 1'b0};
    end
  end

  always_comb begin
    in_contour_nxt = in_contour_r;
    close_pend_nxt = close_pend_r;
    if (close_pend_r && seg_ready) begin
      close_pend_nxt = 1'b0;
    end
    if (take) begin
      in_contour_nxt = !in_ch.last_vertex;
      close_pend_nxt = in_contour_r && in_ch.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_contour_r <= 1'b0;
      close_pend_r <= 1'b0;
    end else begin
      in_contour_r <= in_contour_nxt;
      close_pend_r <= close_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_x_r <= vx;
      prev_y_r <= vy;
      if (!in_contour_r) begin
        first_x_r <= vx;
        first_y_r <= vy;
      end
    end
  end

endmodule

// File: rtl/core/cma_seg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_seg_fifo
// short edge queue between intake and arithmetic
// ----------------------------------------------------------------------------
module cma_seg_fifo import cma_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cma_seg_t push_data,
  input  logic     push_valid,
  output logic     push_ready,
  output cma_seg_t pop_data,
  output logic     pop_valid,
  input  logic     pop_ready
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cma_seg_t            slot_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = count_r != CntW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/cma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_back
// edge term pipeline, running totals and result register
// ----------------------------------------------------------------------------
module cma_back import cma_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ACC_BITS   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cma_seg_t     seg_data,
  input  logic         seg_valid,
  output logic         seg_ready,
  cma_moment_if.source out_ch
);

  localparam int unsigned PW  = 2 * COORD_BITS;   // coordinate product
  localparam int unsigned CW  = PW + 1;           // signed cross product
  localparam int unsigned SW  = COORD_BITS + 1;   // coordinate sum
  localparam int unsigned AW  = COORD_BITS + 2;   // 2*a + b
  localparam int unsigned FW  = PW + 3;           // mixed moment factor
  localparam int unsigned QW  = PW + 2;           // quadratic factor
  localparam int unsigned T1W = CW + SW + 1;
  localparam int unsigned T3W = CW + FW + 1;
  localparam int unsigned T4W = CW + QW + 1;

  logic adv;

  // stage 1: cross product and edge factors
  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [PW-1:0]         p12, p21;
  logic [AW-1:0]         fa, fb;

  logic signed [CW-1:0] c_r;
  logic [SW-1:0]        sx_r, sy_r;
  logic [FW-1:0]        fm_r;
  logic [QW-1:0]        qx_r, qy_r;
  logic                 s1_valid_r, s1_clear_r, s1_emit_r;

  // stage 2: edge terms
  logic signed [CW-1:0]  t0_r;
  logic signed [T1W-1:0] t1_r, t2_r;
  logic signed [T3W-1:0] t3_r;
  logic signed [T4W-1:0] t4_r, t5_r;
  logic                  s2_valid_r, s2_clear_r, s2_emit_r;

  // stage 3: totals
  logic [ACC_BITS-1:0] tot_r   [NumMom];
  logic [ACC_BITS-1:0] tot_nxt [NumMom];
  logic [ACC_BITS-1:0] term    [NumMom];
  logic                out_valid_r;

  // whole pipeline holds while a result waits
  assign adv       = !(out_valid_r && !out_ch.ready);
  assign seg_ready = adv;

  assign x1 = seg_data.x1[COORD_BITS-1:0];
  assign y1 = seg_data.y1[COORD_BITS-1:0];
  assign x2 = seg_data.x2[COORD_BITS-1:0];
  assign y2 = seg_data.y2[COORD_BITS-1:0];

  assign p12 = PW'(x1) * PW'(y2);
  assign p21 = PW'(x2) * PW'(y1);
  assign fa  = AW'({x2, 1'b0}) + AW'(x1);
  assign fb  = AW'({x1, 1'b0}) + AW'(x2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= seg_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r        <= $signed({1'b0, p12}) - $signed({1'b0, p21});
      sx_r       <= SW'(x1) + SW'(x2);
      sy_r       <= SW'(y1) + SW'(y2);
      fm_r       <= FW'(fa) * FW'(y2) + FW'(fb) * FW'(y1);
      qx_r       <= QW'(x1) * QW'(x1) + QW'(x1) * QW'(x2) + QW'(x2) * QW'(x2);
      qy_r       <= QW'(y1) * QW'(y1) + QW'(y1) * QW'(y2) + QW'(y2) * QW'(y2);
      s1_clear_r <= seg_data.clear;
      s1_emit_r  <= seg_data.emit;

      t0_r       <= c_r;
      t1_r       <= c_r * $signed({1'b0, sx_r});
      t2_r       <= c_r * $signed({1'b0, sy_r});
      t3_r       <= c_r * $signed({1'b0, fm_r});
      t4_r       <= c_r * $signed({1'b0, qx_r});
      t5_r       <= c_r * $signed({1'b0, qy_r});
      s2_clear_r <= s1_clear_r;
      s2_emit_r  <= s1_emit_r;
    end
  end

  always_comb begin
    term[MOM_00] = ACC_BITS'(t0_r);
    term[MOM_10] = ACC_BITS'(t1_r);
    term[MOM_01] = ACC_BITS'(t2_r);
    term[MOM_11] = ACC_BITS'(t3_r);
    term[MOM_20] = ACC_BITS'(t4_r);
    term[MOM_02] = ACC_BITS'(t5_r);
    for (int i = 0; i < NumMom; i++) begin
      tot_nxt[i] = (s2_clear_r ? '0 : tot_r[i]) + term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumMom; i++) begin
        tot_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (s2_valid_r) begin
        for (int i = 0; i < NumMom; i++) begin
          tot_r[i] <= tot_nxt[i];
        end
      end
      out_valid_r <= s2_valid_r && s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_emit_r) begin
      out_ch.area_x2       <= $signed(tot_nxt[MOM_00][AreaW-1:0]);
      out_ch.moment_x_x6   <= $signed(tot_nxt[MOM_10][Mom1W-1:0]);
      out_ch.moment_y_x6   <= $signed(tot_nxt[MOM_01][Mom1W-1:0]);
      out_ch.moment_xy_x24 <= $signed(tot_nxt[MOM_11][Mom2W-1:0]);
      out_ch.moment_xx_x12 <= $signed(tot_nxt[MOM_20][Mom2W-1:0]);
      out_ch.moment_yy_x12 <= $signed(tot_nxt[MOM_02][Mom2W-1:0]);
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// File: rtl/core/contour_moment_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_moment_accumulator_unit
// order-2 polygon moments of traced contours by Green's theorem
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   in_ch    | in  | valid / ready | vertex_x, vertex_y, last_vertex,
//            |     |               | new_region
//   out_ch   | out | valid / ready | area_x2, moment_x_x6, moment_y_x6,
//            |     |               | moment_xy_x24, moment_xx_x12, moment_yy_x12
//
// one vertex per cycle while the edge queue has room; a last vertex that ends
// a contour of two or more vertices holds in_ch.ready low while the intake
// pushes the closing edge
// with an empty queue and no stall a result follows its last vertex through
// the closing edge into the queue, the two multiplier stages and the
// accumulate into the result register; a lone-vertex contour has no closing
// edge and skips that first step
// reset clears the contour tracking, the queue, the pipeline valids and the
// six totals; a stalled result holds the back end, the edge queue then fills
// and only after that does in_ch.ready drop
//
module contour_moment_accumulator_unit import cma_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ACC_BITS   = 64,
  parameter int unsigned SEG_DEPTH  = 4
) (
  input logic          clk,
  input logic          rst_n,
  cma_vertex_if.sink   in_ch,
  cma_moment_if.source out_ch
);

  // edges from intake into the queue
  cma_seg_t push_seg;
  logic     push_valid, push_ready;

  // edges from the queue into the arithmetic
  cma_seg_t pop_seg;
  logic     pop_valid, pop_ready;

  // intake: first/previous vertex and closing edge insertion
  cma_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .seg_data (push_seg),
    .seg_valid(push_valid),
    .seg_ready(push_ready)
  );

  // decouples intake from stalls of the arithmetic back end
  cma_seg_fifo #(
    .DEPTH(SEG_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (push_seg),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_seg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  // edge terms, running totals, result register
  cma_back #(
    .COORD_BITS(COORD_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .seg_data (pop_seg),
    .seg_valid(pop_valid),
    .seg_ready(pop_ready),
    .out_ch   (out_ch)
  );

endmodule

// File: rtl/core/cma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_checker
// port-level checks of the contour moment accumulator
// ----------------------------------------------------------------------------
module cma_checker import cma_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [AreaW-1:0] area_x2,
  input logic signed [Mom1W-1:0] moment_x_x6,
  input logic signed [Mom2W-1:0] moment_xy_x24
);

  logic in_contour_r;
  logic in_take;

  assign in_take = in_valid && in_ready;

  // contour tracking as seen from the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_contour_r <= 1'b0;
    end else if (in_take) begin
      in_contour_r <= !in_last;
    end
  end

  // closing edge holds in_ready low right after a last vertex that ends a contour
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_last && in_contour_r |=> !in_ready)
    else $error("vertex taken while closing edge pending");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(area_x2) && $stable(moment_x_x6)
                                && $stable(moment_xy_x24))
    else $error("result changed while stalled");

endmodule

bind contour_moment_accumulator_unit cma_checker u_cma_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.last_vertex),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .area_x2      (out_ch.area_x2),
  .moment_x_x6  (out_ch.moment_x_x6),
  .moment_xy_x24(out_ch.moment_xy_x24)
);

// File: sim/contour_moment_accumulator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_moment_accumulator_unit_test
// self-checking bench for the contour moment accumulator
// ----------------------------------------------------------------------------
// contours are pushed through the vertex channel with random gaps while the
// moment channel is stalled at random; a behavioral model of the six region
// totals predicts every emitted moment set and each transaction on the
// result side is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module contour_moment_accumulator_unit_test;
  import cma_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 360;
  localparam int unsigned HOLD_CYCLES   = 160;
  localparam logic [CoordW-1:0] COORD_MAX = '1;

  // one predicted result transaction
  typedef struct {
    logic signed [AreaW-1:0] area;
    logic signed [Mom1W-1:0] mx;
    logic signed [Mom1W-1:0] my;
    logic signed [Mom2W-1:0] mxy;
    logic signed [Mom2W-1:0] mxx;
    logic signed [Mom2W-1:0] myy;
  } moment_set_t;

  logic clk = 1'b0;
  logic rst_n;

  cma_vertex_if vertex_ch ();
  cma_moment_if moment_ch ();

  contour_moment_accumulator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (vertex_ch),
    .out_ch (moment_ch)
  );

  always #5 clk = ~clk;

  // contour tracking and running region totals of the model
  logic [CoordW-1:0] trk_first_x = '0;
  logic [CoordW-1:0] trk_first_y = '0;
  logic [CoordW-1:0] trk_prev_x  = '0;
  logic [CoordW-1:0] trk_prev_y  = '0;
  bit                trk_open    = 1'b0;
  logic [63:0]       region_sum [NumMom];

  moment_set_t pending_moments[$];

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned vertices_sent = 0;
  int unsigned hold_request  = 0;  // long receiver hold-off, taken by the sink
  bit          idle_off      = 1'b0;

  initial foreach (region_sum[i]) region_sum[i] = '0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_moments.size());
    $display("FAIL contour_moment_accumulator_unit");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // green's theorem terms of one edge, all modulo 2^64
  function automatic void add_edge_terms(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                                         logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
    logic [63:0] x1, y1, x2, y2, c;
    x1 = 64'(ax);
    y1 = 64'(ay);
    x2 = 64'(bx);
    y2 = 64'(by);
    c  = x1 * y2 - x2 * y1;
    region_sum[MOM_00] += c;
    region_sum[MOM_10] += c * (x1 + x2);
    region_sum[MOM_01] += c * (y1 + y2);
    region_sum[MOM_11] += c * ((64'd2 * x2 + x1) * y2 + (x2 + 64'd2 * x1) * y1);
    region_sum[MOM_20] += c * (x1 * x1 + x1 * x2 + x2 * x2);
    region_sum[MOM_02] += c * (y1 * y1 + y1 * y2 + y2 * y2);
  endfunction

  function automatic void predict_vertex(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                         bit last, bit fresh);
    moment_set_t want;
    if (!trk_open) begin
      // new_region only counts on a contour's first vertex
      if (fresh) foreach (region_sum[i]) region_sum[i] = '0;
      trk_first_x = x;
      trk_first_y = y;
      trk_open    = 1'b1;
    end else begin
      add_edge_terms(trk_prev_x, trk_prev_y, x, y);
    end
    trk_prev_x = x;
    trk_prev_y = y;
    if (last) begin
      // closing edge; zero for a single-vertex contour
      add_edge_terms(x, y, trk_first_x, trk_first_y);
      trk_open  = 1'b0;
      want.area = region_sum[MOM_00][AreaW-1:0];
      want.mx   = region_sum[MOM_10][Mom1W-1:0];
      want.my   = region_sum[MOM_01][Mom1W-1:0];
      want.mxy  = region_sum[MOM_11][Mom2W-1:0];
      want.mxx  = region_sum[MOM_20][Mom2W-1:0];
      want.myy  = region_sum[MOM_02][Mom2W-1:0];
      pending_moments.push_back(want);
    end
  endfunction

  // ------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic signed [63:0] got,
                             logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_moments();
    moment_set_t want;
    if (pending_moments.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, area_x2 %0d",
                                moment_ch.area_x2));
      return;
    end
    want = pending_moments.pop_front();
    check_field("area_x2",       moment_ch.area_x2,       want.area);
    check_field("moment_x_x6",   moment_ch.moment_x_x6,   want.mx);
    check_field("moment_y_x6",   moment_ch.moment_y_x6,   want.my);
    check_field("moment_xy_x24", moment_ch.moment_xy_x24, want.mxy);
    check_field("moment_xx_x12", moment_ch.moment_xx_x12, want.mxx);
    check_field("moment_yy_x12", moment_ch.moment_yy_x12, want.myy);
  endtask

  always @(posedge clk) begin
    if (rst_n && moment_ch.valid && moment_ch.ready) check_moments();
  end

  // result sink: random stall before each transaction, or a long hold-off
  initial begin : result_sink
    int unsigned stall;
    moment_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_off ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        moment_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      moment_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(moment_ch.valid && moment_ch.ready) && hold_request == 0);
    end
  end

  // ------------------------------------------------------------- stimulus

  // valid stays high across back-to-back vertices
  task automatic send_vertex(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                             bit last, bit fresh);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      vertex_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex_ch.valid       <= 1'b1;
    vertex_ch.vertex_x    <= x;
    vertex_ch.vertex_y    <= y;
    vertex_ch.last_vertex <= last;
    vertex_ch.new_region  <= fresh;
    do @(posedge clk); while (!vertex_ch.ready);
    predict_vertex(x, y, last, fresh);
    vertices_sent++;
  endtask

  task automatic pause_until_drained();
    vertex_ch.valid <= 1'b0;
    while (pending_moments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // biased toward the field extremes
  function automatic logic [CoordW-1:0] pick_coord(logic [CoordW-1:0] hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return hi;
      default: return CoordW'($urandom_range(0, hi));
    endcase
  endfunction

  // stray new_region on later vertices must be ignored
  task automatic send_contour(int unsigned n, bit fresh, logic [CoordW-1:0] hi);
    for (int unsigned i = 0; i < n; i++)
      send_vertex(pick_coord(hi), pick_coord(hi), i == n - 1,
                  (i == 0) ? fresh : ($urandom_range(0, 7) == 0));
  endtask

  // --------------------------------------------------------------- tests

  task automatic test_directed_shapes();
    // full-range square, counter-clockwise
    send_vertex(0, 0, 0, 1);
    send_vertex(COORD_MAX, 0, 0, 0);
    send_vertex(COORD_MAX, COORD_MAX, 0, 0);
    send_vertex(0, COORD_MAX, 1, 0);
    // again without clearing: area field wraps
    send_vertex(0, 0, 0, 0);
    send_vertex(COORD_MAX, 0, 0, 0);
    send_vertex(COORD_MAX, COORD_MAX, 0, 0);
    send_vertex(0, COORD_MAX, 1, 0);
    // clockwise hole cancels one square
    send_vertex(0, 0, 0, 0);
    send_vertex(0, COORD_MAX, 0, 0);
    send_vertex(COORD_MAX, COORD_MAX, 0, 0);
    send_vertex(COORD_MAX, 0, 1, 0);
    // single-vertex contour clears and emits zero
    send_vertex(COORD_MAX, COORD_MAX, 1, 1);
    // new_region in mid-contour is ignored
    send_vertex(10, 20, 0, 1);
    send_vertex(4000, 100, 0, 1);
    send_vertex(2048, 3900, 1, 0);
    // two-vertex contour adds nothing
    send_vertex(1234, 2345, 0, 0);
    send_vertex(3000, 17, 1, 0);
    // alternating bit patterns
    send_vertex(12'hAAA, 12'h555, 0, 1);
    send_vertex(12'h555, 12'hAAA, 0, 0);
    send_vertex(COORD_MAX, 0, 1, 0);
    pause_until_drained();
  endtask

  task automatic test_random_regions();
    int unsigned n_contours, n_vert;
    logic [CoordW-1:0] hi;
    while (vertices_sent < RANDOM_ITEMS + 21) begin
      idle_off   = ($urandom_range(0, 5) == 0);
      n_contours = $urandom_range(1, 4);
      for (int unsigned k = 0; k < n_contours; k++) begin
        case ($urandom_range(0, 9))
          0:       n_vert = 1;
          1:       n_vert = 2;
          default: n_vert = $urandom_range(3, 8);
        endcase
        case ($urandom_range(0, 5))
          0:       hi = 12'd15;
          1:       hi = 12'd255;
          default: hi = COORD_MAX;
        endcase
        // a region mostly starts fresh, sometimes it keeps accumulating
        send_contour(n_vert, (k == 0) && ($urandom_range(0, 4) != 0), hi);
      end
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end
    idle_off = 1'b0;
    pause_until_drained();
  endtask

  // results pile up behind a held sink until the vertex side stalls
  task automatic test_output_backpressure();
    idle_off     = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int unsigned k = 0; k < 15; k++)
      send_contour(3, $urandom_range(0, 1), COORD_MAX);
    idle_off = 1'b0;
    pause_until_drained();
  endtask

  // sender waits for every result between contours
  task automatic test_quiet_pause();
    for (int unsigned k = 0; k < 5; k++) begin
      send_contour($urandom_range(1, 5), 1, COORD_MAX);
      pause_until_drained();
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    vertex_ch.valid       = 1'b0;
    vertex_ch.vertex_x    = '0;
    vertex_ch.vertex_y    = '0;
    vertex_ch.last_vertex = 1'b0;
    vertex_ch.new_region  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_random_regions();
    test_output_backpressure();
    test_quiet_pause();
    pause_until_drained();
    if (error_count == 0) begin
      $display("PASS contour_moment_accumulator_unit");
    end else begin
      $display("FAIL contour_moment_accumulator_unit");
    end
    $finish;
  end

endmodule

// File: contour_moment_accumulator_unit.f
rtl/core/cma_pkg.sv
rtl/core/cma_channels.sv
rtl/core/cma_front.sv
rtl/core/cma_seg_fifo.sv
rtl/core/cma_back.sv
rtl/core/contour_moment_accumulator_unit.sv
rtl/core/cma_checker.sv
sim/contour_moment_accumulator_unit_test.sv
